FILE: rtl/core/snbt_pkg.sv
// snbt_pkg: shared types, character codes and token typing for the tagged-text lexer.
// Used by snbt_lex_core, snbt_res_fifo, snbt_token_lexer and snbt_lex_checker.
`timescale 1ns / 1ps
`default_nettype none

package snbt_pkg;

	// lexer modes; the fourth code is unreachable and behaves as normal
	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_STRING = 2'd1,
		MODE_ESCAPE = 2'd2
	} mode_t;

	localparam logic [3:0] TT_IDENT    = 4'd0;
	localparam logic [3:0] TT_STRING   = 4'd1;
	localparam logic [3:0] TT_INT      = 4'd2;
	localparam logic [3:0] TT_FLOAT    = 4'd3;
	localparam logic [3:0] TT_DOUBLE   = 4'd4;
	localparam logic [3:0] TT_BYTE     = 4'd5;
	localparam logic [3:0] TT_SHORT    = 4'd6;
	localparam logic [3:0] TT_LONG     = 4'd7;
	localparam logic [3:0] TT_COLON    = 4'd8;
	localparam logic [3:0] TT_LBRACE   = 4'd9;
	localparam logic [3:0] TT_RBRACE   = 4'd10;
	localparam logic [3:0] TT_LBRACKET = 4'd11;
	localparam logic [3:0] TT_RBRACKET = 4'd12;
	localparam logic [3:0] TT_COMMA    = 4'd13;

	localparam logic [7:0] CH_END    = 8'hFF;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_LO_D   = 8'h64;
	localparam logic [7:0] CH_UP_D   = 8'h44;
	localparam logic [7:0] CH_LO_B   = 8'h62;
	localparam logic [7:0] CH_UP_B   = 8'h42;
	localparam logic [7:0] CH_LO_S   = 8'h73;
	localparam logic [7:0] CH_UP_S   = 8'h53;
	localparam logic [7:0] CH_LO_I   = 8'h69;
	localparam logic [7:0] CH_UP_I   = 8'h49;
	localparam logic [7:0] CH_LO_L   = 8'h6C;
	localparam logic [7:0] CH_UP_L   = 8'h4C;

	// result queue: one item gives at most two results
	localparam int unsigned FIFO_DEPTH = 4;

	typedef struct packed {
		logic       kind;
		logic [3:0] ttype;
		logic [7:0] vbyte;
		logic       last;
	} result_t;

	// results of one processed item, in order
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} lex_out_t;

	// numeric tokens start with a digit or minus; suffix letter picks the width
	function automatic logic [3:0] type_of_token(input logic [7:0] first_b,
	                                             input logic [7:0] last_b);
		logic [3:0] t;
		t = TT_IDENT;
		if (((first_b >= CH_ZERO) && (first_b <= CH_NINE)) || (first_b == CH_MINUS)) begin
			unique case (last_b) inside
				CH_LO_F, CH_UP_F: t = TT_FLOAT;
				CH_LO_D, CH_UP_D: t = TT_DOUBLE;
				CH_LO_B, CH_UP_B: t = TT_BYTE;
				CH_LO_S, CH_UP_S: t = TT_SHORT;
				CH_LO_L, CH_UP_L: t = TT_LONG;
				default:          t = TT_INT;
			endcase
		end
		return t;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/snbt_token_lexer.sv
// Tagged-text lexer: one byte in per transfer, value bytes and token ends out.
// Input channel: in_valid/in_stall with text_byte and end_of_input. Output
// channel: out_valid/out_stall with result_kind, token_type, value_byte and
// last_of_run. A value byte (result_kind 0) streams out as soon as it is seen;
// the token type (result_kind 1) follows when whitespace, punctuation, a quote,
// the 0xFF marker or end_of_input closes the token. Punctuation gives its own
// token after closing the pending one, so one input byte yields zero, one or
// two results; last_of_run marks the final one.
// An accepted byte is held in the input register; its results are then written into
// the result queue, whose head is offered on out_valid.
// Throughput: one byte per cycle while the queue has room; a byte with two results
// is absorbed by a four-entry result queue, which gives them out one at a time. The input register holds
// its byte whenever the queue has fewer than two free slots.
// Reset (arst_n low): normal mode, no pending token, queue empty, both valids low.
// While out_stall is high the offered result holds; input keeps flowing until the
// queue has fewer than two free slots, then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module snbt_token_lexer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            result_kind,
	output logic [3:0]      token_type,
	output logic [7:0]      value_byte,
	output logic            last_of_run
);
	import snbt_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       room;
	logic       proc;
	lex_out_t   lex_res;
	result_t    head;

	assign proc     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= text_byte;
			end_s1  <= end_of_input;
		end
	end

	snbt_lex_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.proc    (proc),
		.byte_in (byte_s1),
		.end_in  (end_s1),
		.res     (lex_res)
	);

	snbt_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (proc),
		.wdata  (lex_res),
		.room   (room),
		.rvalid (out_valid),
		.rstall (out_stall),
		.rdata  (head)
	);

	assign result_kind = head.kind;
	assign token_type  = head.ttype;
	assign value_byte  = head.vbyte;
	assign last_of_run = head.last;

endmodule

`default_nettype wire

FILE: rtl/core/snbt_lex_core.sv
// snbt_lex_core: lexer state registers and per-byte decode into up to two results.
// Depends on snbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snbt_lex_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              proc,
	input  wire logic [7:0]        byte_in,
	input  wire logic              end_in,
	output snbt_pkg::lex_out_t     res
);
	import snbt_pkg::*;

	mode_t      mode_q, mode_d;
	logic       pending_q, pending_d;
	logic [7:0] first_q, first_d;
	logic [7:0] last_q, last_d;

	logic       close_v;
	logic       other_v;
	result_t    close_r;
	result_t    other_r;
	logic       app_v;
	logic [7:0] app_b;
	logic       esc_ok;
	logic [7:0] esc_b;

	always_comb begin
		esc_ok = 1'b1;
		esc_b  = CH_BSLASH;
		unique case (byte_in)
			CH_BSLASH: esc_b = CH_BSLASH;
			CH_LO_N:   esc_b = CH_LF;
			CH_LO_T:   esc_b = CH_TAB;
			CH_LO_R:   esc_b = CH_CR;
			default:   esc_ok = 1'b0;
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		close_v = 1'b0;
		other_v = 1'b0;
		app_v   = 1'b0;
		app_b   = byte_in;
		other_r = '{kind: 1'b1, ttype: TT_IDENT, vbyte: 8'h00, last: 1'b1};
		close_r = '{kind: 1'b1, ttype: type_of_token(first_q, last_q), vbyte: 8'h00,
		            last: 1'b1};

		if (end_in || (byte_in == CH_END)) begin
			close_v = pending_q;
			mode_d  = MODE_NORMAL;
		end else if (mode_q == MODE_STRING) begin
			if (byte_in == CH_BSLASH) begin
				mode_d = MODE_ESCAPE;
			end else if (byte_in == CH_QUOTE) begin
				mode_d        = MODE_NORMAL;
				other_v       = 1'b1;
				other_r.ttype = TT_STRING;
			end else begin
				app_v = 1'b1;
			end
		end else if (mode_q == MODE_ESCAPE) begin
			app_v  = esc_ok;
			app_b  = esc_b;
			mode_d = MODE_STRING;
		end else begin
			unique case (byte_in) inside
				CH_SPACE, CH_TAB, CH_CR, CH_LF: close_v = pending_q;
				CH_COLON, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA: begin
					close_v = pending_q;
					other_v = 1'b1;
				end
				CH_QUOTE: begin
					close_v = pending_q;
					mode_d  = MODE_STRING;
				end
				default: begin
					mode_d = MODE_NORMAL;
					app_v  = 1'b1;
				end
			endcase
			unique case (byte_in)
				CH_COLON:  other_r.ttype = TT_COLON;
				CH_LBRACE: other_r.ttype = TT_LBRACE;
				CH_RBRACE: other_r.ttype = TT_RBRACE;
				CH_LBRACK: other_r.ttype = TT_LBRACKET;
				CH_RBRACK: other_r.ttype = TT_RBRACKET;
				default:   other_r.ttype = TT_COMMA;
			endcase
		end

		if (app_v) begin
			other_v = 1'b1;
			other_r = '{kind: 1'b0, ttype: TT_IDENT, vbyte: app_b, last: 1'b1};
		end

		pending_d = pending_q;
		first_d   = first_q;
		last_d    = last_q;
		if (close_v || (other_v && other_r.kind)) begin
			pending_d = 1'b0;
		end
		if (app_v) begin
			pending_d = 1'b1;
			last_d    = app_b;
			if (!pending_q) begin
				first_d = app_b;
			end
		end

		// a pending close always goes out ahead of the punctuation token
		res.r1 = other_r;
		if (close_v) begin
			res.r0      = close_r;
			res.r0.last = !other_v;
		end else begin
			res.r0 = other_r;
		end
		res.count = 2'(close_v) + 2'(other_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			pending_q <= 1'b0;
			first_q   <= 8'h00;
			last_q    <= 8'h00;
		end else if (proc) begin
			mode_q    <= mode_d;
			pending_q <= pending_d;
			first_q   <= first_d;
			last_q    <= last_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/snbt_res_fifo.sv
// snbt_res_fifo: small result queue, takes up to two results per cycle, gives one while rstall is low.
// Depends on snbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snbt_res_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire snbt_pkg::lex_out_t wdata,
	output logic                   room,
	output logic                   rvalid,
	input  wire logic              rstall,
	output snbt_pkg::result_t      rdata
);
	import snbt_pkg::*;

	localparam int unsigned PW = $clog2(FIFO_DEPTH);
	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

	result_t       mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic [1:0]    n_push;
	logic          pop;

	assign n_push = push ? wdata.count : 2'd0;
	assign rvalid = (count_q != '0);
	assign pop    = rvalid && !rstall;
	assign rdata  = mem_q[rd_ptr_q];
	// room for a two-result item regardless of this cycle's read
	assign room   = (count_q <= CW'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_ptr_q] <= wdata.r0;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_ptr_q + PW'(1)] <= wdata.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(n_push);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + CW'(n_push) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/snbt_lex_checker.sv
// snbt_lex_checker: port-level checks for snbt_token_lexer, bound to the top level.
// Sees only the top-level ports; token codes come from snbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snbt_lex_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       result_kind,
	input wire logic [3:0] token_type,
	input wire logic [7:0] value_byte,
	input wire logic       last_of_run
);
	import snbt_pkg::*;

	// a stalled result holds until transferred
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind) &&
		$stable(token_type) && $stable(value_byte) && $stable(last_of_run))
		else $error("stalled result changed");

	// a value byte never shares its input with another result
	a_value_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_kind |-> last_of_run && (token_type == TT_IDENT))
		else $error("value byte not alone or typed");

	// token-end results carry no byte
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind |-> (value_byte == 8'd0) && (token_type <= TT_COMMA))
		else $error("malformed token end");

	// a result not last in its run is a closed token followed by punctuation
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=>
		out_valid && result_kind && last_of_run && (token_type >= TT_COLON))
		else $error("bad second result");

endmodule

bind snbt_token_lexer snbt_lex_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_kind (result_kind),
	.token_type  (token_type),
	.value_byte  (value_byte),
	.last_of_run (last_of_run)
);

`default_nettype wire
